// ===== hdl/sorted_max_priority_queue_core_assert.svh =====
// Assertion macros for the sorted max-priority queue core.
// Needs no package; the including module supplies clock, reset and signals.
`ifndef SORTED_MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_MAX_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SMPQ_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/smpq_pkg.sv =====
// Package of the sorted max-priority queue: sizes, status codes, sequencer
// states and the structs passed between the core's modules. No dependencies.
`timescale 1ns / 1ps

package smpq_pkg;

	localparam int DEPTH = 64;
	localparam int DW    = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} smpq_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OP,
		S_PSH,
		S_PUT,
		S_POP,
		S_RHEAD,
		S_RTAIL,
		S_REND,
		S_FIN
	} smpq_state_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic [AW-1:0] raddr;
	} smpq_mem_req_t;

	typedef struct packed {
		logic [AW-1:0]        idx;
		logic                 down;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
	} smpq_unit_req_t;

	typedef struct packed {
		logic [AW-1:0] idx_nxt;
		logic          lt;
	} smpq_unit_rsp_t;

	typedef struct packed {
		logic signed [DW-1:0] popped;
		smpq_status_t         status;
		logic signed [DW-1:0] largest;
		logic signed [DW-1:0] smallest;
		logic [CNT_W-1:0]     count;
		logic                 empty;
		logic                 full;
	} smpq_res_t;

endpackage

// ===== hdl/smpq_store.sv =====
// Entry store of the queue: one write port, one read port, registered read.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

module smpq_store (
	input  logic                   clk,
	input  smpq_pkg::smpq_mem_req_t req,
	output logic [smpq_pkg::DW-1:0] rdata
);
	import smpq_pkg::*;

	logic [DW-1:0] mem [DEPTH];

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

// ===== hdl/smpq_unit.sv =====
// Shared step unit: signed compare of two entries and one index step.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

module smpq_unit (
	input  smpq_pkg::smpq_unit_req_t req,
	output smpq_pkg::smpq_unit_rsp_t rsp
);
	import smpq_pkg::*;

	// Compare signed and step the index toward head or tail
	always_comb begin
		rsp.lt      = req.a < req.b;
		rsp.idx_nxt = req.down ? req.idx - AW'(1) : req.idx + AW'(1);
	end

endmodule

// ===== hdl/smpq_ctrl.sv =====
// Sequencer of the queue: runs the insertion scan, the pop shift and the
// head/tail refresh over the entry store. Depends on smpq_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "sorted_max_priority_queue_core_assert.svh"

module smpq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic signed [smpq_pkg::DW-1:0] value,
	input  logic                     out_ok,
	output logic                     done,
	output smpq_pkg::smpq_res_t      res,
	output smpq_pkg::smpq_mem_req_t  mem_req,
	input  logic [smpq_pkg::DW-1:0]  mem_rdata,
	output smpq_pkg::smpq_unit_req_t unit_req,
	input  smpq_pkg::smpq_unit_rsp_t unit_rsp
);
	import smpq_pkg::*;

	smpq_state_t          state_q, state_d;
	logic                 kind_q;
	logic signed [DW-1:0] value_q;
	logic [CNT_W-1:0]     occ_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        k_q;
	logic signed [DW-1:0] popped_q;
	smpq_status_t         status_q;
	logic signed [DW-1:0] largest_q;
	logic signed [DW-1:0] smallest_q;

	logic             is_full;
	logic             is_empty;
	logic [CNT_W-1:0] occ_m1;
	logic             last_pop;
	logic             in_acc;

	assign is_full  = occ_q == CNT_W'(DEPTH);
	assign is_empty = occ_q == '0;
	assign occ_m1   = occ_q - CNT_W'(1);
	assign last_pop = CNT_W'(i_q) == occ_m1;
	assign in_acc   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_OP;
			end
			S_OP: begin
				if (!kind_q) begin
					if (is_full || is_empty) state_d = S_RHEAD;
					else state_d = S_PSH;
				end else begin
					if (is_empty || occ_q == CNT_W'(1)) state_d = S_RHEAD;
					else state_d = S_POP;
				end
			end
			S_PSH: begin
				if (!unit_rsp.lt) state_d = S_RHEAD;
				else if (i_q == '0) state_d = S_PUT;
			end
			S_PUT: state_d = S_RHEAD;
			S_POP: begin
				if (last_pop) state_d = S_RHEAD;
			end
			S_RHEAD: state_d = S_RTAIL;
			S_RTAIL: state_d = S_REND;
			S_REND:  state_d = S_FIN;
			S_FIN: begin
				if (out_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Drive store, unit and handshake controls
	always_comb begin
		in_ready      = 1'b0;
		done          = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = k_q;
		mem_req.wdata = mem_rdata;
		mem_req.raddr = '0;
		unit_req.idx  = i_q;
		unit_req.down = state_q == S_PSH;
		unit_req.a    = $signed(mem_rdata);
		unit_req.b    = value_q;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_OP: begin
				if (!kind_q) begin
					if (!is_full && is_empty) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = '0;
						mem_req.wdata = value_q;
					end
					mem_req.raddr = occ_m1[AW-1:0];
				end else begin
					mem_req.raddr = AW'(1);
				end
			end
			S_PSH: begin
				mem_req.raddr = unit_rsp.idx_nxt;
				mem_req.we    = 1'b1;
				if (!unit_rsp.lt) mem_req.wdata = value_q;
			end
			S_PUT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = value_q;
			end
			S_POP: begin
				mem_req.we    = 1'b1;
				mem_req.raddr = unit_rsp.idx_nxt;
			end
			S_RHEAD: mem_req.raddr = '0;
			S_RTAIL: mem_req.raddr = occ_m1[AW-1:0];
			S_REND:  mem_req.raddr = '0;
			S_FIN:   done = out_ok;
			default: in_ready = 1'b0;
		endcase
	end

	// Advance state and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_OP: begin
					if (!kind_q && !is_full && is_empty) occ_q <= occ_q + CNT_W'(1);
					if (kind_q && occ_q == CNT_W'(1)) occ_q <= '0;
				end
				S_PSH: begin
					if (!unit_rsp.lt) occ_q <= occ_q + CNT_W'(1);
				end
				S_PUT: occ_q <= occ_q + CNT_W'(1);
				S_POP: begin
					if (last_pop) occ_q <= occ_m1;
				end
				default: occ_q <= occ_q;
			endcase
		end
	end

	// Hold the transaction, scan indexes and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					kind_q  <= kind;
					value_q <= value;
				end
			end
			S_OP: begin
				status_q <= STAT_OK;
				popped_q <= '0;
				if (!kind_q) begin
					if (is_full) status_q <= STAT_FULL;
					i_q <= occ_m1[AW-1:0];
					k_q <= occ_q[AW-1:0];
				end else begin
					if (is_empty) status_q <= STAT_EMPTY;
					else popped_q <= largest_q;
					i_q <= AW'(1);
					k_q <= '0;
				end
			end
			S_PSH, S_POP: begin
				i_q <= unit_rsp.idx_nxt;
				k_q <= i_q;
			end
			S_RTAIL: largest_q  <= is_empty ? '0 : $signed(mem_rdata);
			S_REND:  smallest_q <= is_empty ? '0 : $signed(mem_rdata);
			default: i_q <= i_q;
		endcase
	end

	// Report the queue as it stands
	always_comb begin
		res.popped   = popped_q;
		res.status   = status_q;
		res.largest  = largest_q;
		res.smallest = smallest_q;
		res.count    = occ_q;
		res.empty    = is_empty;
		res.full     = is_full;
	end

	`SMPQ_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == S_PSH || state_q == S_POP, CNT_W'(i_q) < occ_q, "scan index beyond stored entries")
	`SMPQ_ASSERT_NOW(a_write_in_range, clk, arst_n, mem_req.we, CNT_W'(mem_req.waddr) < occ_q || (CNT_W'(mem_req.waddr) == occ_q && !is_full), "store write outside open slots")
	`SMPQ_ASSERT_NEXT(a_occ_step, clk, arst_n, 1'b1, occ_q == $past(occ_q) || occ_q == $past(occ_q) + CNT_W'(1) || occ_q == $past(occ_q) - CNT_W'(1), "occupancy moved by more than one")
	`SMPQ_ASSERT_NOW(a_occ_bound, clk, arst_n, state_q == S_FIN, occ_q <= CNT_W'(DEPTH), "occupancy above depth")

endmodule

// ===== hdl/sorted_max_priority_queue_core.sv =====
// Sorted max-priority queue core: push with in-order insertion, pop of largest.
// A push scans from the tail, moving each smaller entry down a slot, then writes the new value;
// a pop shifts the rest toward the head. Refused ops, a push into an empty queue and a pop of
// the last entry skip the scan. Head and tail are then refreshed and the result is registered.
// One op at a time, held by result stalls; the store's single write port moves one entry per cycle.
// Async active-low reset empties the queue. Depends on smpq_pkg, smpq_store, smpq_unit, smpq_ctrl.
`timescale 1ns / 1ps

module sorted_max_priority_queue_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [smpq_pkg::DW-1:0]    value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [smpq_pkg::DW-1:0]    popped,
	output logic [1:0]                        status,
	output logic signed [smpq_pkg::DW-1:0]    largest,
	output logic signed [smpq_pkg::DW-1:0]    smallest,
	output logic [smpq_pkg::CNT_W-1:0]        count,
	output logic                              empty_res,
	output logic                              full_res
);
	import smpq_pkg::*;

	smpq_mem_req_t  mem_req;
	logic [DW-1:0]  mem_rdata;
	smpq_unit_req_t unit_req;
	smpq_unit_rsp_t unit_rsp;
	smpq_res_t      res;
	logic           done;
	logic           out_ok;
	logic           out_valid_q;
	smpq_res_t      out_q;

	assign out_ok = !out_valid_q || out_ready;

	smpq_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	smpq_unit u_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_ok    (out_ok),
		.done      (done),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.unit_req  (unit_req),
		.unit_rsp  (unit_rsp)
	);

	// Hold the result transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign popped    = out_q.popped;
	assign status    = 2'(out_q.status);
	assign largest   = out_q.largest;
	assign smallest  = out_q.smallest;
	assign count     = out_q.count;
	assign empty_res = out_q.empty;
	assign full_res  = out_q.full;

endmodule

// ===== bench/tb_sorted_max_priority_queue_core.sv =====
// Self-checking bench for sorted_max_priority_queue_core: a directed pass, then
// random push/pop phases. A mirror of the sorted store predicts every result.
// Depends on smpq_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_sorted_max_priority_queue_core;

	import smpq_pkg::*;

	localparam logic OP_PUSH      = 1'b0;
	localparam logic OP_POP       = 1'b1;
	localparam int   RAND_OPS     = 1800;
	localparam int   DRAIN_CYCLES = DEPTH + 16;
	localparam int   HOLD_AT      = 250;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   CYCLE_LIMIT  = 1200000;
	localparam int   MAX_REPORTS  = 10;

	typedef struct {
		logic                 kind;
		logic signed [DW-1:0] value;
	} queue_op_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = OP_PUSH;
	logic signed [DW-1:0] value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [DW-1:0] popped;
	logic [1:0]           status;
	logic signed [DW-1:0] largest;
	logic signed [DW-1:0] smallest;
	logic [CNT_W-1:0]     count;
	logic                 empty_res;
	logic                 full_res;

	// Ops waiting to be offered, mirror of the store, predicted snapshots
	queue_op_t            op_q[$];
	logic signed [DW-1:0] sorted_vals[$];
	smpq_res_t            snapshot_q[$];

	logic in_fired = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   hold_done = 0;
	int   in_cnt = 0;
	int   out_cnt = 0;
	int   fail_cnt = 0;
	int   cycle_cnt = 0;
	int   n_push = 0;
	int   n_pop = 0;
	int   n_full = 0;
	int   n_empty = 0;
	int   peak_count = 0;

	sorted_max_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.popped    (popped),
		.status    (status),
		.largest   (largest),
		.smallest  (smallest),
		.count     (count),
		.empty_res (empty_res),
		.full_res  (full_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one op to the mirror and return the snapshot the core must report
	function automatic smpq_res_t apply_op(input logic op, input logic signed [DW-1:0] v);
		smpq_res_t r;
		int        pos;
		r = '0;
		r.status = STAT_OK;
		if (op == OP_PUSH) begin
			if (sorted_vals.size() >= DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				// Insert after every entry greater or equal: ties keep arrival order
				pos = 0;
				while (pos < sorted_vals.size() && sorted_vals[pos] >= v)
					pos++;
				sorted_vals.insert(pos, v);
			end
		end else begin
			if (sorted_vals.size() == 0)
				r.status = STAT_EMPTY;
			else
				r.popped = sorted_vals.pop_front();
		end
		if (sorted_vals.size() > 0) begin
			r.largest  = sorted_vals[0];
			r.smallest = sorted_vals[$];
		end
		r.count = CNT_W'(sorted_vals.size());
		r.empty = (sorted_vals.size() == 0);
		r.full  = (sorted_vals.size() >= DEPTH);
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mix full-range words, a narrow band full of ties, the extremes and a wider band near zero
	function automatic logic signed [DW-1:0] rand_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom;
		if (r < 75)
			return $urandom_range(0, 15) - 8;
		if (r < 88) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return -1;
				3: return 1;
				default: return 0;
			endcase
		end
		return $urandom_range(0, 2000) - 1000;
	endfunction

	task automatic add_op(input logic op, input logic signed [DW-1:0] v);
		queue_op_t c;
		c.kind  = op;
		c.value = v;
		op_q.push_back(c);
	endtask

	// Drop idling now and then on both sides
	function automatic bit calm_phase();
		return ((in_cnt / 150) % 5) == 2;
	endfunction

	// Sender: hold the transaction until taken, then idle or offer the next op
	always @(negedge clk) begin : drive_blk
		queue_op_t c;
		logic      v_n;
		v_n = in_valid;
		if (arst_n && !(in_valid && !in_fired)) begin
			if (in_fired)
				gap_left = calm_phase() ? 0 : idle_len();
			if (gap_left > 0) begin
				gap_left--;
				v_n = 1'b0;
			end else if (op_q.size() > 0) begin
				c = op_q.pop_front();
				v_n = 1'b1;
				kind  <= c.kind;
				value <= c.value;
			end else begin
				v_n = 1'b0;
			end
		end
		in_valid <= v_n;
	end

	// Receiver: random stalls, plus one long hold-off to back up the input side
	always @(negedge clk) begin : ready_blk
		logic r_n;
		r_n = 1'b1;
		if (!arst_n) begin
			r_n = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			r_n = 1'b0;
		end else if (!hold_done && out_cnt >= HOLD_AT) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES - 1;
			r_n = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			r_n = 1'b0;
		end else if (!calm_phase() && $urandom_range(0, 3) == 0) begin
			stall_left = idle_len();
		end
		out_ready <= r_n;
	end

	// Predict on each accepted op, check each accepted result against the oldest
	always @(posedge clk) begin : check_blk
		smpq_res_t want;
		smpq_res_t got;
		in_fired <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = apply_op(kind, value);
				snapshot_q.push_back(want);
				in_cnt++;
				if (want.status == STAT_FULL)
					n_full++;
				else if (want.status == STAT_EMPTY)
					n_empty++;
				else if (kind == OP_PUSH)
					n_push++;
				else
					n_pop++;
				if (want.count > peak_count)
					peak_count = want.count;
			end
			if (out_valid && out_ready) begin
				out_cnt++;
				got.popped   = popped;
				got.status   = smpq_status_t'(status);
				got.largest  = largest;
				got.smallest = smallest;
				got.count    = count;
				got.empty    = empty_res;
				got.full     = full_res;
				if (snapshot_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("[%0t] result %0d with nothing pending", $realtime, out_cnt);
				end else begin
					want = snapshot_q.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS) begin
							$display("[%0t] result %0d mismatch", $realtime, out_cnt);
							$display("  exp popped=%0d st=%0d max=%0d min=%0d cnt=%0d e=%0b f=%0b",
								want.popped, want.status, want.largest, want.smallest,
								want.count, want.empty, want.full);
							$display("  got popped=%0d st=%0d max=%0d min=%0d cnt=%0d e=%0b f=%0b",
								got.popped, got.status, got.largest, got.smallest,
								got.count, got.empty, got.full);
						end
					end
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, snapshot_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stim_blk
		int n_gen;
		int phase_len;
		int push_pct;

		// Directed: refused pop, extremes, ties at both ends, drain past empty
		add_op(OP_POP, 32'sh1234_5678);
		add_op(OP_PUSH, 0);
		add_op(OP_PUSH, 32'sh7fff_ffff);
		add_op(OP_PUSH, 32'sh8000_0000);
		add_op(OP_PUSH, -1);
		add_op(OP_PUSH, 1);
		add_op(OP_PUSH, -1);
		add_op(OP_PUSH, 32'sh7fff_ffff);
		add_op(OP_PUSH, 32'sh8000_0000);
		add_op(OP_PUSH, 32'sh5555_5555);
		add_op(OP_PUSH, 32'shaaaa_aaaa);
		repeat (11)
			add_op(OP_POP, $urandom);

		// Random phases: push-heavy ones fill the queue, pop-heavy ones drain it
		n_gen = 0;
		while (n_gen < RAND_OPS) begin
			phase_len = $urandom_range(30, 120);
			case ($urandom_range(0, 3))
				0: push_pct = 95;
				1: push_pct = 10;
				2: push_pct = 55;
				default: push_pct = 75;
			endcase
			repeat (phase_len) begin
				add_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, rand_value());
				n_gen++;
			end
		end

		// Reset once, release on a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every op to be taken and every result to arrive
		@(posedge clk);
		while (op_q.size() != 0 || in_valid)
			@(posedge clk);
		while (snapshot_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d ops: %0d pushes, %0d pops, %0d pushes refused full, %0d pops refused empty",
			in_cnt, n_push, n_pop, n_full, n_empty);
		$display("peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, fail_cnt);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_store.sv
hdl/smpq_unit.sv
hdl/smpq_ctrl.sv
hdl/sorted_max_priority_queue_core.sv
bench/tb_sorted_max_priority_queue_core.sv
